// ===== sv/dbs_pkg.sv =====
// Shared command codes, status codes and result type for the deque/bag store.
package dbs_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_CONTAINS   = 3'd4;
  localparam logic [2:0] CMD_REMOVE     = 3'd5;
  localparam logic [2:0] CMD_PEEK       = 3'd6;
  localparam logic [2:0] CMD_NOP        = 3'd7;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic        is_empty;
    logic [4:0]  entry_count;
    logic [31:0] back_value;
    logic [31:0] front_value;
    logic        found;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== sv/deque_bag_store_top.sv =====
// Top level of the deque/bag store: sequencer, address unit, entry memory, output register.
//
// Input stream: s_tuser carries the command (push front/back, pop front/back,
// contains, remove first match, peek), s_tdata the signed word it acts on.
// Each accepted word gives exactly one result word on the m_ stream with the
// status, found flag, front and back entries, entry count and empty flag.
// Entries live in a ring buffer in a single-port-read memory; one sequencer
// walks it one slot per cycle through a shared address adder.
// Contains scans the entries from the front up to the first match (or all of
// them when nothing matches); remove also moves each entry behind the match
// one slot toward the front. s_tready is high only while the sequencer is
// idle, so the next word is taken in the cycle after a result leaves the
// sequencer, and no new word is accepted while a command is in progress.
// The output register frees the sequencer: a finished result waits there
// while the next word is accepted; if m_tready stays low, the following
// result holds in the sequencer and s_tready stays low.
// Reset (rst, synchronous) empties the store and drops m_tvalid.
module deque_bag_store_top #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], found[2], front_value[34:3], back_value[66:35],
  // entry_count[71:67], is_empty[72], zero[79:73]
  output logic [dbs_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PAD_W = dbs_pkg::OUT_DATA_W - $bits(dbs_pkg::result_t);

  logic                  res_valid;
  logic                  res_ready;
  dbs_pkg::result_t      res;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_WIDTH-1:0] ram_rdata;
  logic [AW-1:0]         agu_base;
  logic [AW-1:0]         agu_off;
  logic [AW-1:0]         agu_addr;
  logic [WORD_WIDTH-1:0] in_value;

  assign in_value  = WORD_WIDTH'($signed(s_tdata));
  assign res_ready = !m_tvalid || m_tready;

  dbs_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_value  (in_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .agu_base  (agu_base),
    .agu_off   (agu_off),
    .agu_addr  (agu_addr)
  );

  dbs_agu #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_agu (
    .base (agu_base),
    .off  (agu_off),
    .addr (agu_addr)
  );

  dbs_ram #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {PAD_W'(0), res};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again while a command is in progress");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("finished result did not reach the output register");

  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.found && res.status != dbs_pkg::STATUS_OK))
    else $error("found flag set on a failed command");

endmodule

// ===== sv/dbs_ram.sv =====
// Entry storage: one write port, one registered read port.
module dbs_ram #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dbs_agu.sv =====
// Shared address unit: base plus offset, wrapped around the ring of DEPTH slots.
module dbs_agu #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] off,
  output logic [AW-1:0] addr
);

  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  always_comb begin
    sum     = SW'(base) + SW'(off);
    wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
    addr    = wrapped[AW-1:0];
  end

endmodule

// ===== sv/dbs_ctrl.sv =====
// Sequencer: runs each command over the ring buffer one memory access per cycle.
module dbs_ctrl #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_cmd,
  input  logic [WORD_WIDTH-1:0] in_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output dbs_pkg::result_t      res,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [WORD_WIDTH-1:0] ram_wdata,
  output logic [AW-1:0]         ram_raddr,
  input  logic [WORD_WIDTH-1:0] ram_rdata,
  output logic [AW-1:0]         agu_base,
  output logic [AW-1:0]         agu_off,
  input  logic [AW-1:0]         agu_addr
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_SHIFT   = 3'd3;
  localparam logic [2:0] ST_FETCH_F = 3'd4;
  localparam logic [2:0] ST_FETCH_B = 3'd5;
  localparam logic [2:0] ST_RESULT  = 3'd6;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [2:0]            state, state_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic [2:0]            cmd, cmd_next;
  logic [WORD_WIDTH-1:0] val, val_next;
  logic [AW-1:0]         idx, idx_next;
  logic [AW-1:0]         wptr, wptr_next;
  logic [AW-1:0]         rd_addr;
  logic [1:0]            status, status_next;
  logic                  found, found_next;
  logic [WORD_WIDTH-1:0] front, front_next;
  logic                  is_full, is_empty;

  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    cmd_next    = cmd;
    val_next    = val;
    idx_next    = idx;
    wptr_next   = wptr;
    status_next = status;
    found_next  = found;
    front_next  = front;
    ram_we      = 1'b0;
    ram_waddr   = agu_addr;
    ram_wdata   = val;
    agu_base    = head;
    agu_off     = '0;
    ram_raddr   = agu_addr;
    in_ready    = (state == ST_IDLE);
    res_valid   = (state == ST_RESULT);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_next    = in_cmd;
          val_next    = in_value;
          status_next = dbs_pkg::STATUS_OK;
          found_next  = 1'b0;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_FETCH_F;
        case (cmd)
          dbs_pkg::CMD_PUSH_FRONT: begin
            agu_off = AW'(DEPTH - 1);
            if (is_full) begin
              status_next = dbs_pkg::STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              head_next  = agu_addr;
              count_next = count + CW'(1);
            end
          end
          dbs_pkg::CMD_PUSH_BACK: begin
            agu_off = AW'(count);
            if (is_full) begin
              status_next = dbs_pkg::STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          dbs_pkg::CMD_POP_FRONT: begin
            agu_off = AW'(1);
            if (is_empty) begin
              status_next = dbs_pkg::STATUS_EMPTY;
            end else begin
              head_next  = agu_addr;
              count_next = count - CW'(1);
            end
          end
          dbs_pkg::CMD_POP_BACK: begin
            if (is_empty) begin
              status_next = dbs_pkg::STATUS_EMPTY;
            end else begin
              count_next = count - CW'(1);
            end
          end
          dbs_pkg::CMD_CONTAINS, dbs_pkg::CMD_REMOVE: begin
            // read slot 0 now, compare it in the scan state
            if (is_empty) begin
              status_next = dbs_pkg::STATUS_EMPTY;
            end else begin
              idx_next   = '0;
              state_next = ST_SCAN;
            end
          end
          dbs_pkg::CMD_PEEK: begin
            if (is_empty) begin
              status_next = dbs_pkg::STATUS_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        // rdata holds entry idx; the read of idx+1 goes out meanwhile
        agu_base = rd_addr;
        agu_off  = AW'(1);
        if (ram_rdata == val) begin
          found_next = 1'b1;
          if (cmd == dbs_pkg::CMD_REMOVE) begin
            if (CW'(idx) + CW'(1) == count) begin
              count_next = count - CW'(1);
              state_next = ST_FETCH_F;
            end else begin
              wptr_next  = rd_addr;
              state_next = ST_SHIFT;
            end
          end else begin
            state_next = ST_FETCH_F;
          end
        end else if (CW'(idx) + CW'(1) == count) begin
          state_next = ST_FETCH_F;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_SHIFT: begin
        // rdata holds entry idx+1; move it down into the slot at wptr
        agu_base   = rd_addr;
        agu_off    = AW'(1);
        ram_we     = 1'b1;
        ram_waddr  = wptr;
        ram_wdata  = ram_rdata;
        wptr_next  = rd_addr;
        idx_next   = idx + AW'(1);
        if (CW'(idx) + CW'(2) == count) begin
          count_next = count - CW'(1);
          state_next = ST_FETCH_F;
        end
      end
      ST_FETCH_F: begin
        ram_raddr  = head;
        state_next = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        front_next = ram_rdata;
        agu_off    = AW'(count - CW'(1));
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // hold the back address so rdata stays on the back entry
        agu_off = AW'(count - CW'(1));
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status;
    res.found       = found;
    res.entry_count = 5'(count);
    res.is_empty    = is_empty;
    if (is_empty) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else begin
      res.front_value = 32'($signed(front));
      res.back_value  = 32'($signed(ram_rdata));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    val     <= val_next;
    idx     <= idx_next;
    wptr    <= wptr_next;
    status  <= status_next;
    found   <= found_next;
    front   <= front_next;
    rd_addr <= ram_raddr;
  end

endmodule

// ===== tb/deque_bag_store_top_tb.sv =====
// Self-checking testbench for deque_bag_store_top: predicts each result word and compares it.
module deque_bag_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [31:0]                    s_tdata;
  logic [2:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [dbs_pkg::OUT_DATA_W-1:0] m_tdata;

  deque_bag_store_top #(.DEPTH(DEPTH), .WORD_WIDTH(32)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  class deque_scoreboard;
    logic [31:0]      store_q[$];
    dbs_pkg::result_t pending_q[$];
    int               errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one accepted command word to the shadow store and queue its result.
    function void note_word(logic [2:0] op, logic [31:0] value);
      dbs_pkg::result_t r;
      int               hit;
      r   = '0;
      hit = -1;
      case (op)
        dbs_pkg::CMD_PUSH_FRONT: begin
          if (store_q.size() >= DEPTH) r.status = dbs_pkg::STATUS_FULL;
          else store_q.push_front(value);
        end
        dbs_pkg::CMD_PUSH_BACK: begin
          if (store_q.size() >= DEPTH) r.status = dbs_pkg::STATUS_FULL;
          else store_q.push_back(value);
        end
        dbs_pkg::CMD_POP_FRONT: begin
          if (store_q.size() == 0) r.status = dbs_pkg::STATUS_EMPTY;
          else void'(store_q.pop_front());
        end
        dbs_pkg::CMD_POP_BACK: begin
          if (store_q.size() == 0) r.status = dbs_pkg::STATUS_EMPTY;
          else void'(store_q.pop_back());
        end
        dbs_pkg::CMD_CONTAINS, dbs_pkg::CMD_REMOVE: begin
          if (store_q.size() == 0) begin
            r.status = dbs_pkg::STATUS_EMPTY;
          end else begin
            for (int i = 0; i < store_q.size(); i++)
              if (hit < 0 && store_q[i] == value) hit = i;
            if (hit >= 0) begin
              r.found = 1'b1;
              if (op == dbs_pkg::CMD_REMOVE) store_q.delete(hit);
            end
          end
        end
        dbs_pkg::CMD_PEEK: begin
          if (store_q.size() == 0) r.status = dbs_pkg::STATUS_EMPTY;
        end
        default: ;
      endcase
      r.entry_count = 5'(store_q.size());
      r.is_empty    = (store_q.size() == 0);
      if (store_q.size() != 0) begin
        r.front_value = store_q[0];
        r.back_value  = store_q[store_q.size()-1];
      end
      pending_q.push_back(r);
    endfunction

    task check_result(logic [dbs_pkg::OUT_DATA_W-1:0] word);
      dbs_pkg::result_t got;
      dbs_pkg::result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result word with nothing pending: %h", word));
      end else begin
        want = pending_q.pop_front();
        got  = dbs_pkg::result_t'(word[$bits(dbs_pkg::result_t)-1:0]);
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.found !== want.found)
          report($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.front_value !== want.front_value)
          report($sformatf("front %h, want %h", got.front_value, want.front_value));
        if (got.back_value !== want.back_value)
          report($sformatf("back %h, want %h", got.back_value, want.back_value));
        if (got.entry_count !== want.entry_count)
          report($sformatf("count %0d, want %0d", got.entry_count, want.entry_count));
        if (got.is_empty !== want.is_empty)
          report($sformatf("empty %0b, want %0b", got.is_empty, want.is_empty));
        if (word[dbs_pkg::OUT_DATA_W-1:$bits(dbs_pkg::result_t)] !== '0)
          report($sformatf("pad bits %h not zero",
                           word[dbs_pkg::OUT_DATA_W-1:$bits(dbs_pkg::result_t)]));
      end
    endtask
  endclass

  deque_scoreboard sb;
  int              cycles = 0;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              words_sent;
  logic [31:0]     value_pool[8];

  always #2 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("[deque_bag_store_top] ERROR");
    $finish;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task send_word(logic [2:0] op, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    sb.note_word(op, value);
    words_sent++;
    @(negedge clk);
  endtask

  // Half the time a value from a small set, so searches and removes hit often.
  function logic [31:0] pick_value();
    if ($urandom_range(3) < 2) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function logic [31:0] search_value();
    int n;
    n = sb.store_q.size();
    if (n != 0 && $urandom_range(1)) return sb.store_q[$urandom_range(n-1)];
    return pick_value();
  endfunction

  task run_random(int target);
    int stop_at;
    int roll;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      roll = $urandom_range(9);
      if (roll < 2) begin
        // fill to full, then push into the full store
        while (sb.store_q.size() < DEPTH)
          send_word($urandom_range(1) ? dbs_pkg::CMD_PUSH_BACK : dbs_pkg::CMD_PUSH_FRONT,
                    pick_value());
        repeat ($urandom_range(1, 2))
          send_word($urandom_range(1) ? dbs_pkg::CMD_PUSH_BACK : dbs_pkg::CMD_PUSH_FRONT,
                    pick_value());
      end else if (roll < 4) begin
        // drain, mixing pops and removes, then send one pop, contains, remove or peek on empty
        while (sb.store_q.size() != 0) begin
          case ($urandom_range(2))
            0: send_word(dbs_pkg::CMD_POP_FRONT, $urandom);
            1: send_word(dbs_pkg::CMD_POP_BACK, $urandom);
            default: send_word(dbs_pkg::CMD_REMOVE, search_value());
          endcase
        end
        send_word(3'($urandom_range(dbs_pkg::CMD_POP_FRONT, dbs_pkg::CMD_PEEK)), $urandom);
      end else begin
        repeat (8) begin
          roll = $urandom_range(99);
          if (roll < 30)
            send_word($urandom_range(1) ? dbs_pkg::CMD_PUSH_BACK : dbs_pkg::CMD_PUSH_FRONT,
                      pick_value());
          else if (roll < 50)
            send_word($urandom_range(1) ? dbs_pkg::CMD_POP_BACK : dbs_pkg::CMD_POP_FRONT,
                      $urandom);
          else if (roll < 85)
            send_word($urandom_range(1) ? dbs_pkg::CMD_REMOVE : dbs_pkg::CMD_CONTAINS,
                      search_value());
          else if (roll < 95)
            send_word(dbs_pkg::CMD_PEEK, $urandom);
          else
            send_word(dbs_pkg::CMD_NOP, $urandom);
        end
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    words_sent     = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 81;
    sb             = new();
    value_pool     = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h1, $urandom, $urandom, $urandom};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed run from an empty store: every command, including the unused code
    send_word(dbs_pkg::CMD_NOP, 32'h0);
    send_word(dbs_pkg::CMD_POP_FRONT, 32'h0);
    send_word(dbs_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
    send_word(dbs_pkg::CMD_CONTAINS, 32'h0);
    send_word(dbs_pkg::CMD_REMOVE, 32'h0);
    send_word(dbs_pkg::CMD_PEEK, 32'h0);
    send_word(dbs_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(dbs_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    send_word(dbs_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(dbs_pkg::CMD_PUSH_BACK, 32'h0);
    send_word(dbs_pkg::CMD_PEEK, 32'h5555_AAAA);
    send_word(dbs_pkg::CMD_CONTAINS, 32'h8000_0000);
    send_word(dbs_pkg::CMD_CONTAINS, 32'h1234_5678);
    send_word(dbs_pkg::CMD_REMOVE, 32'h1234_5678);
    send_word(dbs_pkg::CMD_REMOVE, 32'h7FFF_FFFF);   // middle entry, tail closes up
    send_word(dbs_pkg::CMD_PUSH_BACK, 32'h0);
    send_word(dbs_pkg::CMD_REMOVE, 32'h0);           // duplicate: only the first goes
    send_word(dbs_pkg::CMD_POP_FRONT, 32'h0);
    send_word(dbs_pkg::CMD_POP_BACK, 32'h0);
    send_word(dbs_pkg::CMD_NOP, 32'hAAAA_5555);
    send_word(dbs_pkg::CMD_POP_BACK, 32'h0);
    send_word(dbs_pkg::CMD_POP_FRONT, 32'h0);

    run_random(160);
    send_idle_pct  = 81;
    recv_stall_pct = 7;
    run_random(170);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(170);
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[deque_bag_store_top] OK");
    end else begin
      $display("[deque_bag_store_top] ERROR");
    end
    $finish;
  end

endmodule
